>>> rtl/sphere_frustum_cull_assert.svh
// assertion macros for the sphere frustum cull block
// expects clk and rst_n in the scope of the including module
`ifndef SPHERE_FRUSTUM_CULL_ASSERT_SVH
`define SPHERE_FRUSTUM_CULL_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SFC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfc assertion failed");
`define SFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfc assertion failed");
`else
`define SFC_ASSERT_NOW(label, ante, cons)
`define SFC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/sfc_pkg.sv
// shared types, codes and helpers for the sphere frustum cull block
// no dependencies
`timescale 1ns / 1ps

package sfc_pkg;

    localparam int PLANE_COUNT = 6;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_TEST  = 2'd1;
    localparam logic [1:0] OP_FRAME = 2'd2;

    localparam logic [1:0] CFG_CAMERA_X = 2'd0;
    localparam logic [1:0] CFG_CAMERA_Y = 2'd1;
    localparam logic [1:0] CFG_CAMERA_Z = 2'd2;

    localparam logic [62:0] DIST_CAP = {63{1'b1}};
    localparam logic [15:0] CNT_CAP  = 16'hFFFF;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [2:0]         plane_slot;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic signed [31:0] extent;
        logic [7:0]         entity_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  entity_out;
        logic        visible;
        logic [62:0] dist_sq;
        logic [15:0] visible_total;
        logic [15:0] culled_total;
    } out_item_t;

    typedef struct packed {
        in_item_t item;
        logic     culled;
    } work_t;

    typedef struct packed {
        logic  valid;
        work_t work;
    } lane_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } cam_t;

    function automatic logic [62:0] sat_add(logic [63:0] a, logic [63:0] b);
        logic [62:0] ca;
        logic [62:0] cb;
        logic [63:0] s;
        ca = a[63] ? DIST_CAP : a[62:0];
        cb = b[63] ? DIST_CAP : b[62:0];
        s  = {1'b0, ca} + {1'b0, cb};
        return s[63] ? DIST_CAP : s[62:0];
    endfunction

endpackage

>>> rtl/sfc_cell.sv
// one plane cell: holds one frustum plane and tests passing spheres against it
// depends on sfc_pkg
`timescale 1ns / 1ps

module sfc_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [2:0]     slot,
    input  sfc_pkg::lane_t up,
    output logic           up_adv,
    output sfc_pkg::lane_t down,
    input  logic           down_adv
);

    logic signed [31:0] a_reg;
    logic signed [31:0] b_reg;
    logic signed [31:0] c_reg;
    logic signed [31:0] d_reg;

    sfc_pkg::lane_t     mid_reg;
    logic signed [63:0] pa_reg;
    logic signed [63:0] pb_reg;
    logic signed [63:0] pc_reg;
    logic signed [31:0] pd_reg;

    sfc_pkg::lane_t     down_reg;
    sfc_pkg::lane_t     down_next;

    logic               en_a;
    logic               en_b;
    logic               load_hit;
    logic signed [49:0] plane_dist;
    logic signed [49:0] neg_r;

    assign en_b   = !down_reg.valid || down_adv;
    assign en_a   = !mid_reg.valid || en_b;
    assign up_adv = en_a;
    assign down   = down_reg;

    assign load_hit = en_a && up.valid && (up.work.item.opcode == sfc_pkg::OP_LOAD)
                      && (up.work.item.plane_slot == slot);

    // plane store, written as a load transfer passes this cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
            c_reg <= '0;
            d_reg <= '0;
        end
        else if (load_hit)
        begin
            a_reg <= up.work.item.coord_x;
            b_reg <= up.work.item.coord_y;
            c_reg <= up.work.item.coord_z;
            d_reg <= up.work.item.extent;
        end
    end

    // products stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg <= '0;
        end
        else if (en_a)
        begin
            mid_reg <= up;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            pa_reg <= 64'(a_reg) * 64'(up.work.item.coord_x);
            pb_reg <= 64'(b_reg) * 64'(up.work.item.coord_y);
            pc_reg <= 64'(c_reg) * 64'(up.work.item.coord_z);
            pd_reg <= d_reg;
        end
    end

    // floored sum and compare against minus radius
    always_comb
    begin
        plane_dist = 50'(pa_reg >>> 16) + 50'(pb_reg >>> 16) + 50'(pc_reg >>> 16)
                     + 50'(pd_reg);
        neg_r = -50'(mid_reg.work.item.extent);
        down_next = mid_reg;
        down_next.work.culled = mid_reg.work.culled || (plane_dist < neg_r);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            down_reg <= '0;
        end
        else if (en_b)
        begin
            down_reg <= down_next;
        end
    end

endmodule

>>> rtl/sfc_tail.sv
// tail of the cull chain: camera distance, frame counters and result register
// depends on sfc_pkg
`timescale 1ns / 1ps

module sfc_tail (
    input  logic               clk,
    input  logic               rst_n,
    input  sfc_pkg::cam_t      cam,
    input  sfc_pkg::lane_t     up,
    output logic               up_adv,
    output logic               result_valid,
    input  logic               result_ready,
    output sfc_pkg::out_item_t result
);

    sfc_pkg::lane_t     t1_reg;
    logic [31:0]        mag_x_reg;
    logic [31:0]        mag_y_reg;
    logic [31:0]        mag_z_reg;

    sfc_pkg::lane_t     t2_reg;
    logic [63:0]        sq_x_reg;
    logic [63:0]        sq_y_reg;
    logic [63:0]        sq_z_reg;

    sfc_pkg::lane_t     t3_reg;
    logic [62:0]        sxy_reg;
    logic [63:0]        sz_reg;

    logic               result_valid_reg;
    sfc_pkg::out_item_t result_reg;
    logic [15:0]        vis_cnt_reg;
    logic [15:0]        cul_cnt_reg;

    logic [15:0]        vis_cnt_next;
    logic [15:0]        cul_cnt_next;
    logic [62:0]        dsum;
    logic               en1;
    logic               en2;
    logic               en3;
    logic               en4;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dz;

    assign en4    = !result_valid_reg || result_ready;
    assign en3    = !t3_reg.valid || en4;
    assign en2    = !t2_reg.valid || en3;
    assign en1    = !t1_reg.valid || en2;
    assign up_adv = en1;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign dx = 33'(cam.x) - 33'(up.work.item.coord_x);
    assign dy = 33'(cam.y) - 33'(up.work.item.coord_y);
    assign dz = 33'(cam.z) - 33'(up.work.item.coord_z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg <= '0;
            t2_reg <= '0;
            t3_reg <= '0;
        end
        else
        begin
            if (en1)
            begin
                t1_reg <= up;
            end
            if (en2)
            begin
                t2_reg <= t1_reg;
            end
            if (en3)
            begin
                t3_reg <= t2_reg;
            end
        end
    end

    // magnitudes, squares, first saturating sum
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            mag_x_reg <= dx[32] ? 32'(-dx) : 32'(dx);
            mag_y_reg <= dy[32] ? 32'(-dy) : 32'(dy);
            mag_z_reg <= dz[32] ? 32'(-dz) : 32'(dz);
        end
        if (en2)
        begin
            sq_x_reg <= 64'(mag_x_reg) * 64'(mag_x_reg);
            sq_y_reg <= 64'(mag_y_reg) * 64'(mag_y_reg);
            sq_z_reg <= 64'(mag_z_reg) * 64'(mag_z_reg);
        end
        if (en3)
        begin
            sxy_reg <= sfc_pkg::sat_add(sq_x_reg, sq_y_reg);
            sz_reg  <= sq_z_reg;
        end
    end

    always_comb
    begin
        dsum         = sfc_pkg::sat_add({1'b0, sxy_reg}, sz_reg);
        vis_cnt_next = vis_cnt_reg;
        cul_cnt_next = cul_cnt_reg;
        case (t3_reg.work.item.opcode)
            sfc_pkg::OP_FRAME:
            begin
                vis_cnt_next = '0;
                cul_cnt_next = '0;
            end
            sfc_pkg::OP_TEST:
            begin
                if (t3_reg.work.culled)
                begin
                    if (cul_cnt_reg != sfc_pkg::CNT_CAP)
                    begin
                        cul_cnt_next = cul_cnt_reg + 16'd1;
                    end
                end
                else if (vis_cnt_reg != sfc_pkg::CNT_CAP)
                begin
                    vis_cnt_next = vis_cnt_reg + 16'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // counters and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            vis_cnt_reg      <= '0;
            cul_cnt_reg      <= '0;
        end
        else if (en4)
        begin
            result_valid_reg <= t3_reg.valid && (t3_reg.work.item.opcode == sfc_pkg::OP_TEST);
            if (t3_reg.valid)
            begin
                vis_cnt_reg <= vis_cnt_next;
                cul_cnt_reg <= cul_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            result_reg.entity_out    <= t3_reg.work.item.entity_in;
            result_reg.visible       <= !t3_reg.work.culled;
            result_reg.dist_sq       <= t3_reg.work.culled ? '0 : dsum;
            result_reg.visible_total <= vis_cnt_next;
            result_reg.culled_total  <= cul_cnt_next;
        end
    end

endmodule

>>> rtl/sphere_frustum_cull.sv
// sphere frustum cull: six plane cells in a row followed by the distance and counter tail
// depends on sfc_pkg, sfc_cell, sfc_tail and sphere_frustum_cull_assert.svh
`timescale 1ns / 1ps

// Usage
//   item channel (item_valid/item_ready/item): one transfer per operation.
//   A load writes one plane slot, a frame start clears both counters, a test
//   carries a sphere and gives exactly one result. Slot 6/7 loads write no plane;
//   opcode 3 and tests with an entity index at or above MAX_ENTITIES are dropped.
//   result channel (result_valid/result_ready/result): visibility, squared
//   camera distance and both counters as they stand after that test.
//   cfg channel: camera x, y, z at indexes 0..2, always ready; write only
//   while no operation is in flight.
//   Operations move through the cells in order, so a load or frame start
//   affects exactly the tests behind it.
//   Stages: two per plane cell (products, compare) and four in the tail
//   (magnitudes, squares, sum, result), the first loaded at the transfer edge.
//   Throughput: one item per cycle while the receiver does not stall, set by
//   the products stage of each cell holding its own multipliers.
//   Reset clears planes, counters, camera and pipeline. When the receiver
//   stalls, the result is held and stages fill up behind it; item_ready
//   drops only once the stage ahead of the input is full.

module sphere_frustum_cull #(
    parameter int unsigned MAX_ENTITIES = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  sfc_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output sfc_pkg::out_item_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

`include "sphere_frustum_cull_assert.svh"

    localparam logic [31:0] ENTITY_LIMIT = 32'(MAX_ENTITIES);
    localparam int          LAST_LANE    = sfc_pkg::PLANE_COUNT;

    sfc_pkg::lane_t lane [sfc_pkg::PLANE_COUNT+1];
    logic           adv  [sfc_pkg::PLANE_COUNT+1];
    sfc_pkg::cam_t  cam_reg;
    logic           keep;

    assign cfg_ready  = 1'b1;
    assign item_ready = adv[0];

    assign keep = (item.opcode == sfc_pkg::OP_LOAD) || (item.opcode == sfc_pkg::OP_FRAME)
                  || ((item.opcode == sfc_pkg::OP_TEST)
                      && (32'(item.entity_in) < ENTITY_LIMIT));

    always_comb
    begin
        lane[0].valid       = item_valid && keep;
        lane[0].work.item   = item;
        lane[0].work.culled = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sfc_pkg::CFG_CAMERA_X: cam_reg.x <= cfg_data;
                sfc_pkg::CFG_CAMERA_Y: cam_reg.y <= cfg_data;
                sfc_pkg::CFG_CAMERA_Z: cam_reg.z <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    for (genvar i = 0; i < sfc_pkg::PLANE_COUNT; i++)
    begin : g_cell
        sfc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .slot     (3'(i)),
            .up       (lane[i]),
            .up_adv   (adv[i]),
            .down     (lane[i+1]),
            .down_adv (adv[i+1])
        );
    end

    sfc_tail u_tail (
        .clk          (clk),
        .rst_n        (rst_n),
        .cam          (cam_reg),
        .up           (lane[sfc_pkg::PLANE_COUNT]),
        .up_adv       (adv[sfc_pkg::PLANE_COUNT]),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    `SFC_ASSERT_NEXT(a_chain_hold, lane[LAST_LANE].valid && !adv[LAST_LANE], $stable(lane[LAST_LANE]))
    `SFC_ASSERT_NOW(a_cull_zero, result_valid && !result.visible, result.dist_sq == '0)
    `SFC_ASSERT_NOW(a_vis_count, result_valid && result.visible, result.visible_total != '0)
    `SFC_ASSERT_NOW(a_cul_count, result_valid && !result.visible, result.culled_total != '0)

endmodule
